// ----- design/ata_pio_host_sequencer_top_macros.svh -----
// Assertion macros for the ATA PIO host sequencer checker
`ifndef ATA_PIO_HOST_SEQUENCER_TOP_MACROS_SVH
`define ATA_PIO_HOST_SEQUENCER_TOP_MACROS_SVH
// implication checked at every edge outside reset
`define APS_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// next-cycle implication
`define APS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`endif

// ----- design/aps_pkg.sv -----
// ----------------------------------------------------------------------------
// aps_pkg
// Types and constants shared by the ATA PIO host sequencer.
// ----------------------------------------------------------------------------
package aps_pkg;
    localparam int unsigned WordsPerSector = 256;
    localparam int unsigned WlW = $clog2(WordsPerSector + 1);
    localparam int unsigned QDepth = 4;
    localparam int unsigned QAw = $clog2(QDepth);

    typedef enum logic [2:0] {
        OP_READ = 3'd0, OP_WRITE = 3'd1, OP_STATUS = 3'd2,
        OP_DATA = 3'd3, OP_HOST = 3'd4, OP_TICK = 3'd5
    } t_op;

    typedef enum logic [2:0] {
        K_REG_WR = 3'd0, K_STAT_RD = 3'd1, K_DATA_RD = 3'd2,
        K_DATA_WR = 3'd3, K_HOST = 3'd4, K_DONE = 3'd5
    } t_kind;

    typedef enum logic [2:0] {
        DC_OK = 3'd0, DC_ABSENT = 3'd1, DC_ERROR = 3'd2,
        DC_FAULT = 3'd3, DC_TIMEOUT = 3'd4
    } t_code;

    typedef enum logic [3:0] {
        PH_IDLE, PH_READY1, PH_DRQ_RD, PH_RD_DATA, PH_DRQ_WR, PH_WR_DATA, PH_READY2
    } t_phase;

    // one result item
    typedef struct packed {
        logic [2:0]  kind;
        logic [2:0]  reg_offset;
        logic [15:0] word;
        logic [2:0]  done_code;
        logic        last;
    } t_res;

    // one queued result burst for the back end: up to 6 results
    typedef struct packed {
        logic [2:0] cnt;
        t_res [5:0] res;
    } t_burst;

    localparam int unsigned BurstW = $bits(t_burst);

    localparam logic [2:0] REG_DATA = 3'd0;
    localparam logic [2:0] REG_COUNT = 3'd2;
    localparam logic [2:0] REG_LBA_LO = 3'd3;
    localparam logic [2:0] REG_LBA_MID = 3'd4;
    localparam logic [2:0] REG_LBA_HI = 3'd5;
    localparam logic [2:0] REG_DRVHEAD = 3'd6;
    localparam logic [2:0] REG_CMDSTAT = 3'd7;

    localparam logic [7:0] ST_ERR = 8'h01;
    localparam logic [7:0] ST_DRQ = 8'h08;
    localparam logic [7:0] ST_DF = 8'h20;
    localparam logic [7:0] ST_DRDY = 8'h40;
    localparam logic [7:0] ST_BSY = 8'h80;

    localparam logic [0:0] CFG_PRESENT = 1'b0;
    localparam logic [0:0] CFG_TIMEOUT = 1'b1;

    function automatic t_res mk(input t_kind k, input logic [2:0] off,
                                input logic [15:0] w, input t_code c);
        t_res r;
        r.kind = k;
        r.reg_offset = off;
        r.word = w;
        r.done_code = c;
        r.last = 1'b0;
        return r;
    endfunction
endpackage

// ----- design/aps_front.sv -----
// ----------------------------------------------------------------------------
// aps_front
// Accepts transactions, runs the phase machine and emits a result burst.
// ----------------------------------------------------------------------------
module aps_front (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic                 i_cfg_idx,
    input  logic [15:0]          i_cfg_data,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  logic [2:0]           i_operation,
    input  logic                 i_drive,
    input  logic [27:0]          i_lba,
    input  logic [7:0]           i_sector_count,
    input  logic [15:0]          i_value,
    input  logic                 i_q_full,
    output logic                 o_push,
    output aps_pkg::t_burst      o_burst
);
    import aps_pkg::*;

    logic [1:0]     r_present;
    logic [15:0]    r_timeout;
    t_phase         r_phase, n_phase;
    logic           r_writing, n_writing;
    logic [7:0]     r_sec_left, n_sec_left;
    logic [WlW-1:0] r_words_left, n_words_left;
    logic [15:0]    r_elapsed, n_elapsed;
    logic [27:0]    r_plba, n_plba;
    logic [7:0]     r_pcnt, n_pcnt;
    logic           acc;
    logic [7:0]     st;
    logic [2:0]     n;
    t_res [5:0]     res;
    logic [WlW-1:0] wl_dec;
    logic [7:0]     sec_dec;

    assign o_ready = !i_q_full;
    assign acc = i_valid && o_ready;
    assign st = i_value[7:0];
    assign wl_dec = r_words_left - WlW'(1);
    assign sec_dec = r_sec_left - 8'd1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_present <= '0;
            r_timeout <= 16'd50;
        end else if (i_cfg_we) begin
            if (i_cfg_idx == CFG_PRESENT) r_present <= i_cfg_data[1:0];
            else r_timeout <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_writing <= 1'b0;
            r_sec_left <= '0;
            r_words_left <= '0;
            r_elapsed <= '0;
            r_plba <= '0;
            r_pcnt <= '0;
        end else if (acc) begin
            r_phase <= n_phase;
            r_writing <= n_writing;
            r_sec_left <= n_sec_left;
            r_words_left <= n_words_left;
            r_elapsed <= n_elapsed;
            r_plba <= n_plba;
            r_pcnt <= n_pcnt;
        end
    end

    always_comb begin
        n_phase = r_phase;
        n_writing = r_writing;
        n_sec_left = r_sec_left;
        n_words_left = r_words_left;
        n_elapsed = r_elapsed;
        n_plba = r_plba;
        n_pcnt = r_pcnt;
        n = '0;
        res = '0;
        unique case (i_operation)
            OP_TICK: begin
                if (r_phase != PH_IDLE && r_elapsed != 16'hFFFF)
                    n_elapsed = r_elapsed + 16'd1;
            end
            OP_READ, OP_WRITE: begin
                if (r_phase == PH_IDLE) begin
                    if (!r_present[i_drive]) begin
                        res[0] = mk(K_DONE, '0, '0, DC_ABSENT);
                        n = 3'd1;
                    end else begin
                        n_writing = i_operation[0];
                        n_plba = i_lba;
                        n_pcnt = i_sector_count;
                        res[0] = mk(K_REG_WR, REG_DRVHEAD,
                            {8'h00, (i_drive ? 8'hF0 : 8'hE0) | {4'h0, i_lba[27:24]}},
                            DC_OK);
                        res[1] = mk(K_STAT_RD, REG_CMDSTAT, '0, DC_OK);
                        n = 3'd2;
                        n_phase = PH_READY1;
                        n_elapsed = '0;
                    end
                end
            end
            OP_STATUS: begin
                priority case (r_phase)
                    PH_READY1, PH_READY2: begin
                        if ((st & ST_ERR) != 0) begin
                            res[0] = mk(K_DONE, '0, '0, DC_ERROR);
                            n = 3'd1; n_phase = PH_IDLE;
                        end else if ((st & ST_DF) != 0) begin
                            res[0] = mk(K_DONE, '0, '0, DC_FAULT);
                            n = 3'd1; n_phase = PH_IDLE;
                        end else if ((st & ST_BSY) == 0 && (st & ST_DRDY) != 0) begin
                            if (r_phase == PH_READY2) begin
                                res[0] = mk(K_DONE, '0, '0, DC_OK);
                                n = 3'd1; n_phase = PH_IDLE;
                            end else begin
                                res[0] = mk(K_REG_WR, REG_COUNT, {8'h00, r_pcnt}, DC_OK);
                                res[1] = mk(K_REG_WR, REG_LBA_LO, {8'h00, r_plba[7:0]},
                                    DC_OK);
                                res[2] = mk(K_REG_WR, REG_LBA_MID, {8'h00, r_plba[15:8]},
                                    DC_OK);
                                res[3] = mk(K_REG_WR, REG_LBA_HI, {8'h00, r_plba[23:16]},
                                    DC_OK);
                                res[4] = mk(K_REG_WR, REG_CMDSTAT,
                                    r_writing ? 16'h0030 : 16'h0020, DC_OK);
                                n = 3'd6;
                                n_sec_left = r_pcnt;
                                n_elapsed = '0;
                                if (r_writing) begin
                                    res[5] = mk(K_STAT_RD, REG_CMDSTAT, '0, DC_OK);
                                    n_phase = (r_pcnt != 0) ? PH_DRQ_WR : PH_READY2;
                                end else if (r_pcnt != 0) begin
                                    res[5] = mk(K_STAT_RD, REG_CMDSTAT, '0, DC_OK);
                                    n_phase = PH_DRQ_RD;
                                end else begin
                                    res[5] = mk(K_DONE, '0, '0, DC_OK);
                                    n_phase = PH_IDLE;
                                end
                            end
                        end else if (r_elapsed > r_timeout) begin
                            res[0] = mk(K_DONE, '0, '0, DC_TIMEOUT);
                            n = 3'd1; n_phase = PH_IDLE;
                        end else begin
                            res[0] = mk(K_STAT_RD, REG_CMDSTAT, '0, DC_OK);
                            n = 3'd1;
                        end
                    end
                    PH_DRQ_RD: begin
                        if ((st & ST_ERR) != 0) begin
                            res[0] = mk(K_DONE, '0, '0, DC_ERROR);
                            n = 3'd1; n_phase = PH_IDLE;
                        end else if ((st & ST_DRQ) != 0) begin
                            n_phase = PH_RD_DATA;
                            n_words_left = WlW'(WordsPerSector);
                            res[0] = mk(K_DATA_RD, REG_DATA, '0, DC_OK);
                            n = 3'd1;
                        end else begin
                            res[0] = mk(K_STAT_RD, REG_CMDSTAT, '0, DC_OK);
                            n = 3'd1;
                        end
                    end
                    PH_DRQ_WR: begin
                        if ((st & ST_ERR) != 0) begin
                            res[0] = mk(K_DONE, '0, '0, DC_ERROR);
                            n = 3'd1; n_phase = PH_IDLE;
                        end else if ((st & ST_DF) != 0) begin
                            res[0] = mk(K_DONE, '0, '0, DC_FAULT);
                            n = 3'd1; n_phase = PH_IDLE;
                        end else if ((st & ST_DRQ) != 0) begin
                            n_phase = PH_WR_DATA;
                            n_words_left = WlW'(WordsPerSector);
                        end else if (r_elapsed > r_timeout) begin
                            res[0] = mk(K_DONE, '0, '0, DC_TIMEOUT);
                            n = 3'd1; n_phase = PH_IDLE;
                        end else begin
                            res[0] = mk(K_STAT_RD, REG_CMDSTAT, '0, DC_OK);
                            n = 3'd1;
                        end
                    end
                    default: ;
                endcase
            end
            OP_DATA: begin
                if (r_phase == PH_RD_DATA) begin
                    res[0] = mk(K_HOST, '0, i_value, DC_OK);
                    n = 3'd2;
                    n_words_left = wl_dec;
                    if (wl_dec != 0) begin
                        res[1] = mk(K_DATA_RD, REG_DATA, '0, DC_OK);
                    end else begin
                        n_sec_left = sec_dec;
                        if (sec_dec != 0) begin
                            res[1] = mk(K_STAT_RD, REG_CMDSTAT, '0, DC_OK);
                            n_phase = PH_DRQ_RD;
                            n_elapsed = '0;
                        end else begin
                            res[1] = mk(K_DONE, '0, '0, DC_OK);
                            n_phase = PH_IDLE;
                        end
                    end
                end
            end
            OP_HOST: begin
                if (r_phase == PH_WR_DATA) begin
                    res[0] = mk(K_DATA_WR, REG_DATA, i_value, DC_OK);
                    n = 3'd1;
                    n_words_left = wl_dec;
                    if (wl_dec == 0) begin
                        n_sec_left = sec_dec;
                        res[1] = mk(K_STAT_RD, REG_CMDSTAT, '0, DC_OK);
                        n = 3'd2;
                        n_phase = (sec_dec != 0) ? PH_DRQ_WR : PH_READY2;
                        n_elapsed = '0;
                    end
                end
            end
            default: ;
        endcase
        for (int k = 0; k < 6; k++)
            if (3'(k + 1) == n) res[k].last = 1'b1;
    end

    assign o_push = acc && (n != 0);
    assign o_burst.cnt = n;
    assign o_burst.res = res;
endmodule

// ----- design/aps_queue.sv -----
// ----------------------------------------------------------------------------
// aps_queue
// Short FIFO of result bursts between front and back end.
// ----------------------------------------------------------------------------
module aps_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  aps_pkg::t_burst i_burst,
    output logic            o_full,
    output logic            o_empty,
    input  logic            i_pop,
    output aps_pkg::t_burst o_burst
);
    import aps_pkg::*;

    t_burst          r_mem [QDepth];
    logic [QAw-1:0]  r_wp, r_rp;
    logic [QAw:0]    r_cnt;

    assign o_full = (r_cnt == (QAw+1)'(QDepth));
    assign o_empty = (r_cnt == '0);
    assign o_burst = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wp] <= i_burst;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= '0;
            r_rp <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) r_wp <= r_wp + QAw'(1);
            if (i_pop) r_rp <= r_rp + QAw'(1);
            r_cnt <= r_cnt + (QAw+1)'(i_push) - (QAw+1)'(i_pop);
        end
    end
endmodule

// ----- design/aps_back.sv -----
// ----------------------------------------------------------------------------
// aps_back
// Plays out one queued burst a result per cycle into the output register, while the receiver is ready.
// ----------------------------------------------------------------------------
module aps_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_empty,
    input  aps_pkg::t_burst i_burst,
    output logic            o_pop,
    output logic            o_valid,
    input  logic            i_ready,
    output aps_pkg::t_res   o_res
);
    import aps_pkg::*;

    logic [2:0] r_idx;
    logic       r_valid;
    t_res       r_res;
    logic       load;
    logic       last_one;

    assign last_one = (r_idx + 3'd1) == i_burst.cnt;
    assign load = !i_empty && (!r_valid || i_ready);
    assign o_pop = load && last_one;
    assign o_valid = r_valid;
    assign o_res = r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx <= '0;
        end else begin
            if (load) begin
                r_valid <= 1'b1;
                r_idx <= last_one ? 3'd0 : r_idx + 3'd1;
            end else if (i_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) r_res <= i_burst.res[r_idx];
    end
endmodule

// ----- design/ata_pio_host_sequencer_top.sv -----
// ----------------------------------------------------------------------------
// ata_pio_host_sequencer_top
// ATA PIO LBA28 host sequencer, polled primary channel.
// ----------------------------------------------------------------------------
// Input channel (i_valid/o_ready) carries commands, status and data replies,
// host words and ticks. Output channel (o_valid/i_ready) carries register
// writes, status/data reads, data writes, host words and done codes; o_last
// marks the final result of one input transaction.
// The front end takes one transaction per cycle while the queue is not full
// and turns it into a burst of 0..6 results in that cycle; a 4-entry burst
// queue feeds the back end, which drives one result per cycle from its output
// register while the receiver is ready. The first result of a transaction
// passes through a queue entry and then the output register.
// When the receiver stalls the queue fills and o_ready drops; inputs that
// give no result still need a free queue slot to be taken.
// Reset (synchronous, active low) returns to idle, clears the queue,
// drive_present to 0 and timeout to 50 ticks.
// ----------------------------------------------------------------------------
module ata_pio_host_sequencer_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_idx,
    input  logic [15:0] i_cfg_data,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [2:0]  i_operation,
    input  logic        i_drive,
    input  logic [27:0] i_lba,
    input  logic [7:0]  i_sector_count,
    input  logic [15:0] i_value,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [2:0]  o_kind,
    output logic [2:0]  o_reg_offset,
    output logic [15:0] o_word,
    output logic [2:0]  o_done_code,
    output logic        o_last
);
    import aps_pkg::*;

    logic   q_full, q_empty, push, pop;
    t_burst f_burst, q_burst;
    t_res   res;

    aps_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data),
        .i_valid(i_valid), .o_ready(o_ready),
        .i_operation(i_operation), .i_drive(i_drive), .i_lba(i_lba),
        .i_sector_count(i_sector_count), .i_value(i_value),
        .i_q_full(q_full), .o_push(push), .o_burst(f_burst)
    );

    aps_queue u_queue (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_push(push), .i_burst(f_burst), .o_full(q_full), .o_empty(q_empty),
        .i_pop(pop), .o_burst(q_burst)
    );

    aps_back u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_empty(q_empty), .i_burst(q_burst), .o_pop(pop),
        .o_valid(o_valid), .i_ready(i_ready), .o_res(res)
    );

    assign o_kind = res.kind;
    assign o_reg_offset = res.reg_offset;
    assign o_word = res.word;
    assign o_done_code = res.done_code;
    assign o_last = res.last;
endmodule

// ----- design/aps_checker.sv -----
// ----------------------------------------------------------------------------
// aps_checker
// Port-level checks for the ATA PIO host sequencer.
// ----------------------------------------------------------------------------
`include "ata_pio_host_sequencer_top_macros.svh"
module aps_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_valid,
    input logic        i_ready,
    input logic [2:0]  o_kind,
    input logic [2:0]  o_reg_offset,
    input logic [15:0] o_word,
    input logic [2:0]  o_done_code,
    input logic        o_last
);
    import aps_pkg::*;

    `APS_ASSERT_NEXT(a_hold, i_clk, i_rst_n, o_valid && !i_ready, o_valid && $stable(o_word), "output dropped while stalled")
    `APS_ASSERT_IMP(a_done_last, i_clk, i_rst_n, o_valid && o_kind == K_DONE, o_last, "done is not last")
    `APS_ASSERT_IMP(a_code, i_clk, i_rst_n, o_valid && o_kind != K_DONE, o_done_code == DC_OK, "code on non-done")
    `APS_ASSERT_IMP(a_stat_off, i_clk, i_rst_n, o_valid && o_kind == K_STAT_RD, o_reg_offset == REG_CMDSTAT, "status read offset")
endmodule

bind ata_pio_host_sequencer_top aps_checker u_aps_checker (.*);

// ----- tb/tb_ata_pio_host_sequencer_top.sv -----
// ----------------------------------------------------------------------------
// tb_ata_pio_host_sequencer_top
// Self-checking bench for the ATA PIO LBA28 host sequencer.
// Commands and their drive replies are built as whole sequences. A shadow
// copy of the sequencer picks replies that fit the current phase. The
// predictor computes the expected results for each input transaction when
// it is accepted. The monitor checks each output transaction against the
// oldest expected result. Both sides idle at random, and one long receiver
// stall backs up the result queue.
// ----------------------------------------------------------------------------
module tb_ata_pio_host_sequencer_top;
    import aps_pkg::*;

    typedef struct {
        logic [2:0]  op;
        logic        drv;
        logic [27:0] lba;
        logic [7:0]  cnt;
        logic [15:0] val;
    } item_t;

    typedef struct {
        t_phase      phase;
        logic        writing;
        logic [7:0]  sectors;
        logic [8:0]  words;
        logic [15:0] ticks;
        logic [27:0] lba;
        logic [7:0]  cnt;
    } seq_state_t;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic        i_cfg_idx;
    logic [15:0] i_cfg_data;
    logic        i_valid;
    logic        o_ready;
    logic [2:0]  i_operation;
    logic        i_drive;
    logic [27:0] i_lba;
    logic [7:0]  i_sector_count;
    logic [15:0] i_value;
    logic        o_valid;
    logic        i_ready;
    logic [2:0]  o_kind;
    logic [2:0]  o_reg_offset;
    logic [15:0] o_word;
    logic [2:0]  o_done_code;
    logic        o_last;

    ata_pio_host_sequencer_top dut (.*);

    item_t      pending_items[$];
    t_res       expected_results[$];
    item_t      cur_item;
    seq_state_t model_st;
    seq_state_t plan_st;
    logic [1:0] cfg_present;
    logic [15:0] cfg_timeout;
    int         errors;
    int         in_count;
    int         counted;
    int         in_gap;
    bit         quiet;

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    function automatic t_res rec(t_kind k, logic [2:0] off, logic [15:0] w, t_code c);
        t_res r;
        r.kind = k;
        r.reg_offset = off;
        r.word = w;
        r.done_code = c;
        r.last = 1'b0;
        return r;
    endfunction

    function automatic void seq_step(inout seq_state_t s, input item_t it,
                                     input logic [1:0] pres, input logic [15:0] tmo,
                                     output t_res r[$]);
        logic [7:0] st;
        st = it.val[7:0];
        r = {};
        case (it.op)
            OP_TICK: begin
                if (s.phase != PH_IDLE && s.ticks != 16'hFFFF) s.ticks++;
            end
            OP_READ, OP_WRITE: begin
                if (s.phase == PH_IDLE) begin
                    if (!pres[it.drv]) begin
                        r.push_back(rec(K_DONE, 3'd0, 16'd0, DC_ABSENT));
                    end else begin
                        s.writing = (it.op == OP_WRITE);
                        s.lba = it.lba;
                        s.cnt = it.cnt;
                        r.push_back(rec(K_REG_WR, REG_DRVHEAD,
                            {8'd0, (it.drv ? 8'hF0 : 8'hE0) | {4'd0, it.lba[27:24]}}, DC_OK));
                        r.push_back(rec(K_STAT_RD, REG_CMDSTAT, 16'd0, DC_OK));
                        s.phase = PH_READY1;
                        s.ticks = 0;
                    end
                end
            end
            OP_STATUS: begin
                if (s.phase == PH_READY1 || s.phase == PH_READY2) begin
                    if (st & ST_ERR) begin
                        r.push_back(rec(K_DONE, 3'd0, 16'd0, DC_ERROR));
                        s.phase = PH_IDLE;
                    end else if (st & ST_DF) begin
                        r.push_back(rec(K_DONE, 3'd0, 16'd0, DC_FAULT));
                        s.phase = PH_IDLE;
                    end else if (!(st & ST_BSY) && (st & ST_DRDY)) begin
                        if (s.phase == PH_READY2) begin
                            r.push_back(rec(K_DONE, 3'd0, 16'd0, DC_OK));
                            s.phase = PH_IDLE;
                        end else begin
                            r.push_back(rec(K_REG_WR, REG_COUNT, {8'd0, s.cnt}, DC_OK));
                            r.push_back(rec(K_REG_WR, REG_LBA_LO, {8'd0, s.lba[7:0]}, DC_OK));
                            r.push_back(rec(K_REG_WR, REG_LBA_MID, {8'd0, s.lba[15:8]}, DC_OK));
                            r.push_back(rec(K_REG_WR, REG_LBA_HI, {8'd0, s.lba[23:16]}, DC_OK));
                            r.push_back(rec(K_REG_WR, REG_CMDSTAT,
                                            s.writing ? 16'h30 : 16'h20, DC_OK));
                            s.sectors = s.cnt;
                            if (s.writing || s.sectors != 0) begin
                                r.push_back(rec(K_STAT_RD, REG_CMDSTAT, 16'd0, DC_OK));
                                s.ticks = 0;
                                if (!s.writing) s.phase = PH_DRQ_RD;
                                else s.phase = (s.sectors != 0) ? PH_DRQ_WR : PH_READY2;
                            end else begin
                                r.push_back(rec(K_DONE, 3'd0, 16'd0, DC_OK));
                                s.phase = PH_IDLE;
                            end
                        end
                    end else if (s.ticks > tmo) begin
                        r.push_back(rec(K_DONE, 3'd0, 16'd0, DC_TIMEOUT));
                        s.phase = PH_IDLE;
                    end else begin
                        r.push_back(rec(K_STAT_RD, REG_CMDSTAT, 16'd0, DC_OK));
                    end
                end else if (s.phase == PH_DRQ_RD) begin
                    if (st & ST_ERR) begin
                        r.push_back(rec(K_DONE, 3'd0, 16'd0, DC_ERROR));
                        s.phase = PH_IDLE;
                    end else if (st & ST_DRQ) begin
                        s.phase = PH_RD_DATA;
                        s.words = 9'(WordsPerSector);
                        r.push_back(rec(K_DATA_RD, REG_DATA, 16'd0, DC_OK));
                    end else begin
                        r.push_back(rec(K_STAT_RD, REG_CMDSTAT, 16'd0, DC_OK));
                    end
                end else if (s.phase == PH_DRQ_WR) begin
                    if (st & ST_ERR) begin
                        r.push_back(rec(K_DONE, 3'd0, 16'd0, DC_ERROR));
                        s.phase = PH_IDLE;
                    end else if (st & ST_DF) begin
                        r.push_back(rec(K_DONE, 3'd0, 16'd0, DC_FAULT));
                        s.phase = PH_IDLE;
                    end else if (st & ST_DRQ) begin
                        s.phase = PH_WR_DATA;
                        s.words = 9'(WordsPerSector);
                    end else if (s.ticks > tmo) begin
                        r.push_back(rec(K_DONE, 3'd0, 16'd0, DC_TIMEOUT));
                        s.phase = PH_IDLE;
                    end else begin
                        r.push_back(rec(K_STAT_RD, REG_CMDSTAT, 16'd0, DC_OK));
                    end
                end
            end
            OP_DATA: begin
                if (s.phase == PH_RD_DATA) begin
                    r.push_back(rec(K_HOST, 3'd0, it.val, DC_OK));
                    s.words--;
                    if (s.words != 0) begin
                        r.push_back(rec(K_DATA_RD, REG_DATA, 16'd0, DC_OK));
                    end else begin
                        s.sectors--;
                        if (s.sectors != 0) begin
                            s.phase = PH_DRQ_RD;
                            s.ticks = 0;
                            r.push_back(rec(K_STAT_RD, REG_CMDSTAT, 16'd0, DC_OK));
                        end else begin
                            r.push_back(rec(K_DONE, 3'd0, 16'd0, DC_OK));
                            s.phase = PH_IDLE;
                        end
                    end
                end
            end
            OP_HOST: begin
                if (s.phase == PH_WR_DATA) begin
                    r.push_back(rec(K_DATA_WR, REG_DATA, it.val, DC_OK));
                    s.words--;
                    if (s.words == 0) begin
                        s.sectors--;
                        s.phase = (s.sectors != 0) ? PH_DRQ_WR : PH_READY2;
                        s.ticks = 0;
                        r.push_back(rec(K_STAT_RD, REG_CMDSTAT, 16'd0, DC_OK));
                    end
                end
            end
            default: ;
        endcase
        if (r.size() > 0) r[r.size() - 1].last = 1'b1;
    endfunction

    function automatic seq_state_t idle_state();
        seq_state_t s;
        s.phase = PH_IDLE;
        s.writing = 0;
        s.sectors = 0;
        s.words = 0;
        s.ticks = 0;
        s.lba = 0;
        s.cnt = 0;
        return s;
    endfunction

    // driver
    always @(posedge i_clk) begin
        t_res res[$];
        if (!i_rst_n) begin
            i_valid <= 1'b0;
            in_gap = 0;
        end else begin
            if (i_valid && o_ready) begin
                seq_step(model_st, cur_item, cfg_present, cfg_timeout, res);
                foreach (res[k]) expected_results.push_back(res[k]);
                in_count++;
            end
            if (!i_valid || o_ready) begin
                if (in_gap > 0) begin
                    in_gap--;
                    i_valid <= 1'b0;
                end else if (pending_items.size() > 0) begin
                    cur_item = pending_items.pop_front();
                    i_operation <= cur_item.op;
                    i_drive <= cur_item.drv;
                    i_lba <= cur_item.lba;
                    i_sector_count <= cur_item.cnt;
                    i_value <= cur_item.val;
                    i_valid <= 1'b1;
                    in_gap = quiet ? 0 : $urandom_range(0, 7);
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // monitor and receiver
    int  out_stall;
    int  hold_cycles;
    bit  pressure_done;
    always @(posedge i_clk) begin
        t_res exp_r;
        if (!i_rst_n) begin
            i_ready <= 1'b0;
            out_stall = 0;
            hold_cycles = 0;
        end else begin
            if (o_valid && i_ready) begin
                if (expected_results.size() == 0) begin
                    $display("%0t: unexpected result kind=%0d off=%0d word=%h code=%0d last=%0d",
                             $time, o_kind, o_reg_offset, o_word, o_done_code, o_last);
                    errors++;
                end else begin
                    exp_r = expected_results.pop_front();
                    if (o_kind !== exp_r.kind || o_reg_offset !== exp_r.reg_offset ||
                        o_word !== exp_r.word || o_done_code !== exp_r.done_code ||
                        o_last !== exp_r.last) begin
                        $display("%0t: mismatch expected kind=%0d off=%0d word=%h code=%0d last=%0d",
                                 $time, exp_r.kind, exp_r.reg_offset, exp_r.word,
                                 exp_r.done_code, exp_r.last);
                        $display("%0t:          actual kind=%0d off=%0d word=%h code=%0d last=%0d",
                                 $time, o_kind, o_reg_offset, o_word, o_done_code, o_last);
                        errors++;
                    end
                end
                out_stall = quiet ? 0 : $urandom_range(0, 7);
            end
            if (!pressure_done && in_count >= 120) begin
                pressure_done = 1;
                hold_cycles = 300;
            end
            if (hold_cycles > 0) begin
                hold_cycles--;
                i_ready <= 1'b0;
            end else if (out_stall > 0) begin
                out_stall--;
                i_ready <= 1'b0;
            end else begin
                i_ready <= 1'b1;
            end
        end
    end

    // watchdog
    int idle_cycles;
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && o_ready) || (o_valid && i_ready) || i_cfg_we) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
            if (idle_cycles >= 3000) begin
                $display("simulation failed");
                $finish;
            end
        end
    end

    task automatic send(item_t it, bit noise);
        t_res res[$];
        seq_step(plan_st, it, cfg_present, cfg_timeout, res);
        pending_items.push_back(it);
        if (!noise) counted++;
    endtask

    task automatic send_op(logic [2:0] op, logic drv, logic [27:0] lba, logic [7:0] cnt,
                           logic [15:0] val);
        item_t it;
        it.op = op;
        it.drv = drv;
        it.lba = lba;
        it.cnt = cnt;
        it.val = val;
        send(it, 0);
    endtask

    task automatic send_noise();
        item_t it;
        it.op = $urandom_range(0, 1) ? 3'($urandom_range(6, 7)) : 3'($urandom_range(0, 1));
        if (plan_st.phase == PH_IDLE) it.op = 3'($urandom_range(2, 7));
        if (it.op == OP_TICK) it.op = 3'd7;
        if (plan_st.phase == PH_IDLE && it.op < 3'd6) it.op = 3'd6;
        it.drv = 1'($urandom);
        it.lba = 28'($urandom);
        it.cnt = 8'($urandom);
        it.val = 16'($urandom);
        send(it, 1);
    endtask

    task automatic wait_drained();
        while (pending_items.size() > 0 || i_valid || expected_results.size() > 0)
            @(posedge i_clk);
        repeat (40) @(posedge i_clk);
    endtask

    task automatic write_cfg(logic idx, logic [15:0] data);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= data;
        if (idx == CFG_PRESENT) cfg_present = data[1:0];
        else cfg_timeout = data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // random commands never reach a data phase; a full sector is directed
    task automatic random_command();
        logic [15:0] v;
        logic [2:0]  op;
        int          r;
        op = $urandom_range(0, 1) ? OP_WRITE : OP_READ;
        r = $urandom_range(0, 9);
        send_op(op, 1'($urandom), 28'($urandom),
                (r < 5) ? 8'd0 : 8'($urandom_range(1, 255)), 16'($urandom));
        while (plan_st.phase != PH_IDLE) begin
            if ($urandom_range(0, 9) == 0) send_noise();
            r = $urandom_range(0, 99);
            v = 16'($urandom);
            case (plan_st.phase)
                PH_READY1, PH_READY2, PH_DRQ_WR: begin
                    if ($urandom_range(0, 3) == 0)
                        repeat ($urandom_range(1, 3)) send_op(OP_TICK, 0, 0, 0, 16'($urandom));
                    if (r < 6) begin
                        v = v | 16'(ST_ERR);
                    end else if (r < 10) begin
                        v = (v & ~16'(ST_ERR)) | 16'(ST_DF);
                    end else if (r < 35 || plan_st.phase == PH_DRQ_WR) begin
                        v = v & ~16'(ST_ERR | ST_DF);
                        if (plan_st.phase == PH_DRQ_WR) v = v & ~16'(ST_DRQ);
                        else if ($urandom_range(0, 1)) v = v | 16'(ST_BSY);
                        else v = v & ~16'(ST_DRDY);
                    end else begin
                        v = v & ~16'(ST_ERR | ST_DF);
                        v = (v & ~16'(ST_BSY)) | 16'(ST_DRDY);
                    end
                    send_op(OP_STATUS, 0, 0, 0, v);
                end
                PH_DRQ_RD: begin
                    if (r < 20) v = v | 16'(ST_ERR);
                    else v = v & ~16'(ST_ERR | ST_DRQ);
                    send_op(OP_STATUS, 0, 0, 0, v);
                end
                PH_RD_DATA: send_op(OP_DATA, 0, 0, 0, v);
                PH_WR_DATA: send_op(OP_HOST, 0, 0, 0, v);
                default: ;
            endcase
        end
    endtask

    task automatic random_phase(logic [1:0] pres, logic [15:0] tmo, bit no_idle, int n);
        write_cfg(CFG_PRESENT, {14'd0, pres});
        write_cfg(CFG_TIMEOUT, tmo);
        quiet = no_idle;
        counted = 0;
        while (counted < n) random_command();
        wait_drained();
    endtask

    initial begin
        errors = 0;
        in_count = 0;
        quiet = 0;
        pressure_done = 0;
        cfg_present = 2'd0;
        cfg_timeout = 16'd50;
        model_st = idle_state();
        plan_st = idle_state();
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_idx = 1'b0;
        i_cfg_data = 16'd0;
        i_valid = 1'b0;
        i_ready = 1'b0;
        i_operation = 3'd0;
        i_drive = 1'b0;
        i_lba = 28'd0;
        i_sector_count = 8'd0;
        i_value = 16'd0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: absent drive at reset, then the wait outcomes
        send_op(OP_READ, 0, 28'd0, 8'd0, 16'd0);
        send_op(OP_WRITE, 1, 28'hFFFFFFF, 8'd255, 16'hFFFF);
        wait_drained();
        write_cfg(CFG_PRESENT, 16'd3);
        write_cfg(CFG_TIMEOUT, 16'd1);
        send_op(OP_READ, 0, 28'hFFFFFFF, 8'd0, 16'd0);
        send_op(OP_STATUS, 0, 0, 0, 16'hFF40);
        send_op(OP_WRITE, 1, 28'd0, 8'd0, 16'd0);
        send_op(OP_STATUS, 0, 0, 0, 16'h0050);
        send_op(OP_STATUS, 0, 0, 0, 16'h0080);
        send_op(OP_TICK, 0, 0, 0, 16'd0);
        send_op(OP_TICK, 0, 0, 0, 16'd0);
        send_op(OP_STATUS, 0, 0, 0, 16'h00C0);
        send_op(OP_READ, 1, 28'h0ABCDEF, 8'd255, 16'd0);
        send_op(OP_STATUS, 0, 0, 0, 16'h0041);
        send_op(OP_WRITE, 0, 28'h5A5A5A5, 8'd255, 16'd0);
        send_op(OP_STATUS, 0, 0, 0, 16'h00A0);
        send_op(3'd6, 0, 0, 0, 16'd0);
        send_op(3'd7, 1, 28'hFFFFFFF, 8'hFF, 16'hFFFF);
        send_op(OP_TICK, 0, 0, 0, 16'd0);
        send_op(OP_STATUS, 0, 0, 0, 16'h0040);
        send_op(OP_WRITE, 1, 28'd1, 8'd1, 16'd0);
        send_op(OP_STATUS, 0, 0, 0, 16'h0040);
        send_op(OP_STATUS, 0, 0, 0, 16'h0009);
        send_op(OP_READ, 0, 28'd2, 8'd1, 16'd0);
        send_op(OP_STATUS, 0, 0, 0, 16'h0040);
        send_op(OP_STATUS, 0, 0, 0, 16'h0000);
        send_op(OP_STATUS, 0, 0, 0, 16'h0001);
        // one full sector read
        send_op(OP_READ, 1, 28'h1234567, 8'd1, 16'd0);
        send_op(OP_STATUS, 0, 0, 0, 16'h0050);
        send_op(OP_STATUS, 0, 0, 0, 16'h0000);
        send_op(OP_STATUS, 0, 0, 0, 16'h0008);
        for (int k = 0; k < int'(WordsPerSector); k++)
            send_op(OP_DATA, 0, 0, 0, 16'($urandom));
        wait_drained();

        random_phase(2'd3, 16'd1, 0, 12);
        random_phase(2'd1, 16'd65535, 1, 8);
        random_phase(2'd2, 16'd4, 0, 8);
        random_phase(2'd3, 16'd50, 0, 12);
        random_phase(2'd0, 16'd50, 0, 4);

        if (errors == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end
endmodule
